FILE: src/ptsb_pkg.sv
// ----------------------------------------------------------------------------
// Periodic timer slot bank package
// Shared widths, opcode and slot mode codes, sequencer states and the
// reciprocal constant for the millisecond to tick conversion.
// ----------------------------------------------------------------------------
`default_nettype none

package ptsb_pkg;

	localparam int SLOT_COUNT = 4;
	localparam int KEY_BITS   = 16;

	localparam int OP_W     = 3;
	localparam int MS_W     = 16;
	localparam int RELOAD_W = 13;
	localparam int REMAIN_W = 16;
	localparam int SLOT_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	localparam int S_FIELDS_W = KEY_BITS + MS_W;
	localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = 1 + SLOT_W + SLOT_COUNT;
	localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
	localparam int M_PAD_W    = M_DATA_W - M_FIELDS_W;

	// ms / 10 as (ms * 52429) >> 19, exact for every 16-bit ms
	localparam int PROD_W    = 32;
	localparam int DIV_SHIFT = 19;
	localparam logic [16:0] DIV_MUL = 17'd52429;

	typedef enum logic [OP_W-1:0] {
		OP_TICK   = 3'd0,
		OP_JOIN   = 3'd1,
		OP_REMOVE = 3'd2,
		OP_PAUSE  = 3'd3,
		OP_RUN    = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		MODE_FREE    = 2'd0,
		MODE_PAUSED  = 2'd1,
		MODE_RUNNING = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: src/periodic_timer_slot_bank_top.sv
// Sequence: an accepted item goes from PREP straight to DONE for an unused op,
// and through PREP, SCAN and DONE otherwise (a tick always scans every slot).
// Throughput: one item at a time; s_tready returns the cycle after the result
// is taken. The scan walks one slot per cycle through a single shared
// compare/decrement unit, so SLOT_COUNT sets the worst case.
// Reset: all slots free with zero key and counts, no item in flight.
// ----------------------------------------------------------------------------
// Periodic timer slot bank
// A bank of periodic timer slots handling tick, join, remove, pause and run
// commands, one slot examined per cycle by a shared evaluation unit.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_slot_bank_top (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_tvalid,
	output logic                           s_tready,
	input  wire  [ptsb_pkg::S_DATA_W-1:0]  s_tdata,  // timer_key, period_ms
	input  wire  [ptsb_pkg::OP_W-1:0]      s_tuser,  // op
	output logic                           m_tvalid,
	input  wire                            m_tready,
	output logic [ptsb_pkg::M_DATA_W-1:0]  m_tdata   // ok, slot, fired_mask, pad
);

	import ptsb_pkg::*;

	state_t                state_q, state_d;

	logic [OP_W-1:0]       op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [MS_W-1:0]       period_ms_q;
	logic [PROD_W-1:0]     prod_q;
	logic [SLOT_W-1:0]     idx_q;

	mode_t                 mode_q   [SLOT_COUNT];
	logic [KEY_BITS-1:0]   skey_q   [SLOT_COUNT];
	logic [RELOAD_W-1:0]   reload_q [SLOT_COUNT];
	logic [REMAIN_W-1:0]   remain_q [SLOT_COUNT];

	logic                  ok_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [SLOT_COUNT-1:0] fired_q;

	// shared evaluation unit, looks at slot idx_q
	mode_t                 cur_mode;
	logic [REMAIN_W-1:0]   cur_dec;
	logic                  key_match;
	logic                  is_running;
	logic                  fire;
	logic                  hit;
	logic                  last_slot;
	logic                  op_valid;
	logic [RELOAD_W-1:0]   ticks;

	always_comb begin
		cur_mode   = mode_q[idx_q];
		cur_dec    = remain_q[idx_q] - REMAIN_W'(1);
		key_match  = (skey_q[idx_q] == key_q);
		is_running = (cur_mode == MODE_RUNNING);
		fire       = is_running && (cur_dec == '0);
		last_slot  = (idx_q == SLOT_W'(SLOT_COUNT - 1));
		ticks      = prod_q[DIV_SHIFT +: RELOAD_W];
		op_valid   = (op_q == OP_TICK) || (op_q == OP_JOIN) || (op_q == OP_REMOVE) ||
		             (op_q == OP_PAUSE) || (op_q == OP_RUN);
		case (op_t'(op_q))
			OP_JOIN:   hit = (cur_mode == MODE_FREE);
			OP_REMOVE: hit = (cur_mode != MODE_FREE) && key_match;
			OP_PAUSE:  hit = is_running && key_match;
			OP_RUN:    hit = (cur_mode == MODE_PAUSED) && key_match;
			default:   hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = op_valid ? ST_SCAN : ST_DONE;
			end
			ST_SCAN: begin
				if (last_slot || (hit && (op_q != OP_TICK))) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// command capture and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q    <= 1'b0;
			slot_q  <= '0;
			fired_q <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						ok_q    <= 1'b0;
						slot_q  <= '0;
						fired_q <= '0;
						idx_q   <= '0;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + SLOT_W'(1);
					if (op_q == OP_TICK) begin
						if (fire) begin
							fired_q[idx_q] <= 1'b1;
						end
					end else if (hit) begin
						ok_q   <= 1'b1;
						slot_q <= idx_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			op_q        <= s_tuser;
			key_q       <= s_tdata[KEY_BITS-1:0];
			period_ms_q <= s_tdata[KEY_BITS +: MS_W];
		end
		if (state_q == ST_PREP) begin
			prod_q <= PROD_W'(period_ms_q) * PROD_W'(DIV_MUL);
		end
	end

	// slot state, written at most one slot per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				mode_q[i]   <= MODE_FREE;
				skey_q[i]   <= '0;
				reload_q[i] <= '0;
				remain_q[i] <= '0;
			end
		end else if (state_q == ST_SCAN) begin
			case (op_t'(op_q))
				OP_TICK: begin
					if (is_running) begin
						remain_q[idx_q] <= fire ? REMAIN_W'(reload_q[idx_q]) : cur_dec;
					end
				end
				OP_JOIN: begin
					if (hit) begin
						mode_q[idx_q]   <= MODE_PAUSED;
						skey_q[idx_q]   <= key_q;
						reload_q[idx_q] <= ticks;
						remain_q[idx_q] <= REMAIN_W'(ticks);
					end
				end
				OP_REMOVE: begin
					if (hit) begin
						mode_q[idx_q] <= MODE_FREE;
					end
				end
				OP_PAUSE: begin
					if (hit) begin
						mode_q[idx_q] <= MODE_PAUSED;
					end
				end
				OP_RUN: begin
					if (hit) begin
						mode_q[idx_q] <= MODE_RUNNING;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign m_tdata = {{M_PAD_W{1'b0}}, fired_q, slot_q, ok_q};

	a_busy_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready while a result is pending");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("ready again right after an accepted item");

	a_fired_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (op_q != OP_TICK)) |-> (fired_q == '0))
		else $error("fired mask set on a non-tick item");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !ok_q) |-> (slot_q == '0))
		else $error("slot nonzero on a failed item");

	a_join_paused: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && ok_q && (op_q == OP_JOIN)) |-> (mode_q[slot_q] == MODE_PAUSED))
		else $error("joined slot is not paused");

endmodule

`default_nettype wire
